// ----- rtl/pps_pkg.sv -----
`default_nettype none

package pps_pkg;

  // field widths
  localparam int unsigned RgbWidth    = 24;
  localparam int unsigned CountWidth  = 13;
  localparam int unsigned LineWidth   = 12;
  localparam int unsigned SmallWidth  = 8;
  localparam int unsigned AddrWidth   = 5;
  localparam int unsigned DataWidth   = 32;

  // queue between front and back
  localparam int unsigned QueueDepth  = 4;
  localparam int unsigned PtrWidth    = $clog2(QueueDepth);
  localparam int unsigned FillWidth   = $clog2(QueueDepth + 1);

  // register indexes
  localparam logic [2:0] RegOpenMinBlack    = 3'd0;
  localparam logic [2:0] RegBusyAbove       = 3'd1;
  localparam logic [2:0] RegQuietMaxBlack   = 3'd2;
  localparam logic [2:0] RegQuietLinesNeed  = 3'd3;
  localparam logic [2:0] RegStartPadding    = 3'd4;
  localparam logic [2:0] RegEndExtension    = 3'd5;
  localparam logic [2:0] RegSkipAfterClose  = 3'd6;

  // register reset values
  localparam logic [CountWidth-1:0] RstOpenMinBlack   = 13'd60;
  localparam logic [CountWidth-1:0] RstBusyAbove      = 13'd10;
  localparam logic [CountWidth-1:0] RstQuietMaxBlack  = 13'd10;
  localparam logic [SmallWidth-1:0] RstQuietLinesNeed = 8'd21;
  localparam logic [SmallWidth-1:0] RstStartPadding   = 8'd10;
  localparam logic [SmallWidth-1:0] RstEndExtension   = 8'd0;
  localparam logic [SmallWidth-1:0] RstSkipAfterClose = 8'd0;

  // saturation limits
  localparam logic [SmallWidth-1:0] QuietSat = 8'd255;
  localparam logic [LineWidth-1:0]  EndSat   = 12'd4095;

  typedef struct packed {
    logic [RgbWidth-1:0] pixel_rgb;
    logic                line_end;
    logic                last_line;
  } pps_in_t;

  typedef struct packed {
    logic [LineWidth-1:0] segment_start;
    logic [LineWidth-1:0] segment_end;
    logic [LineWidth-1:0] segment_number;
  } pps_out_t;

  // classified pixel word held in the queue
  typedef struct packed {
    logic black;
    logic line_end;
    logic last_line;
  } pps_item_t;

  typedef struct packed {
    logic [CountWidth-1:0] open_min_black;
    logic [CountWidth-1:0] busy_above;
    logic [CountWidth-1:0] quiet_max_black;
    logic [SmallWidth-1:0] quiet_lines_needed;
    logic [SmallWidth-1:0] start_padding;
    logic [SmallWidth-1:0] end_extension;
    logic [SmallWidth-1:0] skip_after_close;
  } pps_cfg_t;

endpackage

`default_nettype wire

// ----- rtl/pps_cfg.sv -----
`default_nettype none

module pps_cfg
  import pps_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [AddrWidth-1:0] paddr,
  input  wire logic [DataWidth-1:0] pwdata,
  output logic      [DataWidth-1:0] prdata,
  output logic                      pready,
  output pps_cfg_t                  cfg_o
);

  pps_cfg_t   cfg_q;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];
  assign cfg_o   = cfg_q;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.open_min_black     <= RstOpenMinBlack;
      cfg_q.busy_above         <= RstBusyAbove;
      cfg_q.quiet_max_black    <= RstQuietMaxBlack;
      cfg_q.quiet_lines_needed <= RstQuietLinesNeed;
      cfg_q.start_padding      <= RstStartPadding;
      cfg_q.end_extension      <= RstEndExtension;
      cfg_q.skip_after_close   <= RstSkipAfterClose;
    end else if (wr_en) begin
      case (reg_idx)
        RegOpenMinBlack:   cfg_q.open_min_black     <= pwdata[CountWidth-1:0];
        RegBusyAbove:      cfg_q.busy_above         <= pwdata[CountWidth-1:0];
        RegQuietMaxBlack:  cfg_q.quiet_max_black    <= pwdata[CountWidth-1:0];
        RegQuietLinesNeed: cfg_q.quiet_lines_needed <= pwdata[SmallWidth-1:0];
        RegStartPadding:   cfg_q.start_padding      <= pwdata[SmallWidth-1:0];
        RegEndExtension:   cfg_q.end_extension      <= pwdata[SmallWidth-1:0];
        RegSkipAfterClose: cfg_q.skip_after_close   <= pwdata[SmallWidth-1:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (reg_idx)
      RegOpenMinBlack:   prdata = DataWidth'(cfg_q.open_min_black);
      RegBusyAbove:      prdata = DataWidth'(cfg_q.busy_above);
      RegQuietMaxBlack:  prdata = DataWidth'(cfg_q.quiet_max_black);
      RegQuietLinesNeed: prdata = DataWidth'(cfg_q.quiet_lines_needed);
      RegStartPadding:   prdata = DataWidth'(cfg_q.start_padding);
      RegEndExtension:   prdata = DataWidth'(cfg_q.end_extension);
      RegSkipAfterClose: prdata = DataWidth'(cfg_q.skip_after_close);
      default:           prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/pps_front.sv -----
`default_nettype none

module pps_front
  import pps_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire pps_in_t   in_word_i,
  output logic           item_valid_o,
  input  wire logic      item_ready_i,
  output pps_item_t      item_o
);

  pps_item_t            mem_q [QueueDepth];
  logic [PtrWidth-1:0]  wr_ptr_q;
  logic [PtrWidth-1:0]  rd_ptr_q;
  logic [FillWidth-1:0] fill_q;
  logic                 push;
  logic                 pop;
  pps_item_t            item_new;

  // classify the pixel
  assign item_new.black     = (in_word_i.pixel_rgb == '0);
  assign item_new.line_end  = in_word_i.line_end;
  assign item_new.last_line = in_word_i.last_line;

  assign in_stall_o   = (fill_q == FillWidth'(QueueDepth));
  assign push         = in_valid_i && !in_stall_o;
  assign item_valid_o = (fill_q != '0);
  assign pop          = item_valid_o && item_ready_i;
  assign item_o       = mem_q[rd_ptr_q];

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item_new;
    end
  end

  // queue pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        fill_q <= fill_q + 1'b1;
      end else if (pop && !push) begin
        fill_q <= fill_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/pps_back.sv -----
`default_nettype none

module pps_back
  import pps_pkg::*;
#(
  parameter logic [CountWidth-1:0] COUNT_CAP = 13'd4096,
  parameter logic [LineWidth-1:0]  LINE_CAP  = 12'd4095
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire pps_cfg_t  cfg_i,
  input  wire logic      item_valid_i,
  output logic           item_ready_o,
  input  wire pps_item_t item_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output pps_out_t       out_word_o
);

  logic [CountWidth-1:0] black_q, black_d;
  logic [LineWidth-1:0]  line_q, line_d;
  logic                  open_q, open_d;
  logic [SmallWidth-1:0] quiet_q, quiet_d;
  logic [LineWidth-1:0]  oidx_q, oidx_d;
  logic [SmallWidth-1:0] skip_q, skip_d;
  logic [LineWidth-1:0]  done_q, done_d;
  logic                  out_valid_q;
  pps_out_t              out_word_q;

  logic                  take;
  logic                  inc;
  logic [CountWidth-1:0] cnt;
  logic                  open_mid;
  logic [LineWidth-1:0]  oidx_mid;
  logic [SmallWidth-1:0] quiet_mid;
  logic [LineWidth+1:0]  end_sum;
  logic                  produce;
  pps_out_t              res;

  assign item_ready_o = !out_valid_q || !out_stall_i;
  assign take         = item_valid_i && item_ready_o;
  assign out_valid_o  = out_valid_q;
  assign out_word_o   = out_word_q;

  // black count including this pixel
  assign inc = item_i.black && (skip_q == '0) && (black_q < COUNT_CAP);
  assign cnt = black_q + CountWidth'(inc);

  assign end_sum = (LineWidth+2)'(line_q) + (LineWidth+2)'(cfg_i.end_extension)
                 + (LineWidth+2)'(cfg_i.skip_after_close);

  // per pixel count and per line decisions
  always_comb begin
    black_d   = black_q;
    line_d    = line_q;
    open_d    = open_q;
    quiet_d   = quiet_q;
    oidx_d    = oidx_q;
    skip_d    = skip_q;
    done_d    = done_q;
    produce   = 1'b0;
    open_mid  = open_q;
    oidx_mid  = oidx_q;
    quiet_mid = quiet_q;
    res.segment_start  = oidx_q;
    res.segment_end    = (end_sum > (LineWidth+2)'(EndSat)) ? EndSat
                                                            : end_sum[LineWidth-1:0];
    res.segment_number = done_q;
    if (take) begin
      if (!item_i.line_end) begin
        black_d = cnt;
      end else begin
        if (skip_q != '0) begin
          skip_d = skip_q - 1'b1;
        end else begin
          // open test
          if ((cnt >= cfg_i.open_min_black) && !open_q) begin
            open_mid = 1'b1;
            oidx_mid = (line_q > LineWidth'(cfg_i.start_padding))
                     ? line_q - LineWidth'(cfg_i.start_padding) : '0;
          end
          // busy test
          if (cnt > cfg_i.busy_above) begin
            quiet_mid = '0;
          end
          open_d  = open_mid;
          oidx_d  = oidx_mid;
          quiet_d = quiet_mid;
          // quiet test
          if ((cnt <= cfg_i.quiet_max_black) && open_mid) begin
            if ((quiet_mid >= cfg_i.quiet_lines_needed) || item_i.last_line) begin
              produce = 1'b1;
              res.segment_start = oidx_mid;
              done_d  = done_q + 1'b1;
              open_d  = 1'b0;
              skip_d  = cfg_i.skip_after_close;
              quiet_d = SmallWidth'(1);
            end else if (quiet_mid != QuietSat) begin
              quiet_d = quiet_mid + 1'b1;
            end
          end
        end
        black_d = '0;
        // image end restarts the line state
        if (item_i.last_line) begin
          line_d  = '0;
          open_d  = 1'b0;
          quiet_d = '0;
          oidx_d  = '0;
          skip_d  = '0;
        end else if (line_q < LINE_CAP) begin
          line_d = line_q + 1'b1;
        end
      end
    end
  end

  // line state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      black_q <= '0;
      line_q  <= '0;
      open_q  <= 1'b0;
      quiet_q <= '0;
      oidx_q  <= '0;
      skip_q  <= '0;
      done_q  <= '0;
    end else begin
      black_q <= black_d;
      line_q  <= line_d;
      open_q  <= open_d;
      quiet_q <= quiet_d;
      oidx_q  <= oidx_d;
      skip_q  <= skip_d;
      done_q  <= done_d;
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (produce) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output register word
  always_ff @(posedge clk_i) begin
    if (produce) begin
      out_word_q <= res;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/projection_profile_segmenter.sv -----
// path: a pixel word is written into the queue; when the back end takes a line
//   end word that closes a segment, its segment word loads the output register
// throughput: one pixel word per cycle, held off only when the four-entry
//   queue is full, which happens when the output word register stays stalled
// reset: asynchronous active low; clears line state, segment count, queue and
//   output valid, and loads the register reset values
`default_nettype none

module projection_profile_segmenter
  import pps_pkg::*;
#(
  parameter int unsigned MAX_LINES    = 4096,
  parameter int unsigned MAX_LINE_LEN = 4096
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [AddrWidth-1:0] paddr,
  input  wire logic [DataWidth-1:0] pwdata,
  output logic      [DataWidth-1:0] prdata,
  output logic                      pready,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire pps_in_t              in_word_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output pps_out_t                  out_word_o
);

  localparam int unsigned CountCapInt = (MAX_LINE_LEN < 8191) ? MAX_LINE_LEN : 8191;
  localparam int unsigned LineCapInt  = (MAX_LINES - 1 < 4095) ? MAX_LINES - 1 : 4095;
  localparam logic [CountWidth-1:0] CountCap = CountWidth'(CountCapInt);
  localparam logic [LineWidth-1:0]  LineCap  = LineWidth'(LineCapInt);

  pps_cfg_t  cfg;
  logic      item_valid;
  logic      item_ready;
  pps_item_t item;

  // configuration registers
  pps_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // pixel classification and queue
  pps_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_word_i    (in_word_i),
    .item_valid_o (item_valid),
    .item_ready_i (item_ready),
    .item_o       (item)
  );

  // line engine and output word register
  pps_back #(
    .COUNT_CAP (CountCap),
    .LINE_CAP  (LineCap)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .item_valid_i (item_valid),
    .item_ready_o (item_ready),
    .item_i       (item),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_word_o   (out_word_o)
  );

endmodule

`default_nettype wire

// ----- rtl/pps_checker.sv -----
`default_nettype none

module pps_checker
  import pps_pkg::*;
(
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     pready,
  input wire logic     out_valid_o,
  input wire logic     out_stall_i,
  input wire pps_out_t out_word_o
);

  // a stalled output word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("stalled output word changed");

  // a segment never ends before it starts
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_word_o.segment_end >= out_word_o.segment_start)
    else $error("segment end before segment start");

  // no output word while in reset
  assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("output valid during reset");

  // register port never waits
  assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind projection_profile_segmenter pps_checker u_pps_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .pready      (pready),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);

`default_nettype wire
